>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL; every property is clocked on clk
// and switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ial_pkg.sv
`timescale 1ns / 1ps
package ial_pkg;

  // Sizing
  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FREE_DEPTH = 256;

  localparam int unsigned SLOT_AW = $clog2(SLOT_COUNT);
  localparam int unsigned IDX_W   = SLOT_AW + 1;
  localparam int unsigned FREE_AW = $clog2(FREE_DEPTH);
  localparam int unsigned CNT_W   = FREE_AW + 1;

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned LIM_W  = 9;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SET  = 3'd1,
    OP_GET  = 3'd2,
    OP_DEL  = 3'd3,
    OP_NEXT = 3'd4,
    OP_PREV = 3'd5
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FIRST_ID = 2'd0,
    CFG_ID_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIFO_RD,
    S_ADD_WR,
    S_GET_DATA,
    S_WALK,
    S_RETURN,
    S_SCAN_NEXT,
    S_SCAN_PREV,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id_in;
    logic [WORD_BITS-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic                 ok;
    logic [ID_W-1:0]      id_out;
    logic [WORD_BITS-1:0] data_out;
  } out_word_t;

  // Sequencer -> scan unit
  typedef struct packed {
    logic               clr_all;
    logic               occ_we;
    logic [SLOT_AW-1:0] occ_idx;
    logic               occ_val;
    logic               load;
    logic [IDX_W-1:0]   load_idx;
    logic               step_up;
    logic               step_dn;
  } scan_cmd_t;

  // Scan unit -> sequencer
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             hit;
  } scan_st_t;

endpackage

>>> sv/id_allocator_slot_table.sv
`timescale 1ns / 1ps
// Channel  Handshake               Word
// in       in_valid / in_ready     in_data  (op, id_in, data_in)
// out      out_valid / out_ready   out_data (ok, id_out, data_out)
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Set and refused ops go from dispatch to the response state; an add of a fresh ID passes
// S_ADD_WR, get S_GET_DATA, a delete below the top mark S_RETURN; a recycled add reads the
// freed-ID RAM first. Next, prev step past empty slots; a top-mark delete walks down first.
// Synchronous active-low reset empties the table through the occupancy flags.
// One word in flight; in_ready and cfg_ready are high only when idle.
// A result held by out_ready low keeps the next result in the response state, not idle.
module id_allocator_slot_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ial_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ial_pkg::out_word_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ial_pkg::CFG_AW-1:0] cfg_index,
  input  logic [ial_pkg::CFG_DW-1:0] cfg_data
);
  import ial_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  // latched request
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic [ID_W-1:0]      g_r, g_nxt;

  // pool state and registers
  logic [ID_W-1:0]    first_r, first_nxt;
  logic [LIM_W-1:0]   limit_r, limit_nxt;
  logic [LIM_W-1:0]   fresh_r, fresh_nxt;
  logic [ID_W-1:0]    top_r, top_nxt;
  logic [FREE_AW-1:0] head_r, head_nxt;
  logic [FREE_AW-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // result staging and output register
  logic                 res_ok_r, res_ok_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic [WORD_BITS-1:0] res_data_r, res_data_nxt;
  out_word_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // memories
  logic                 slot_we;
  logic [SLOT_AW-1:0]   slot_waddr, slot_raddr;
  logic [WORD_BITS-1:0] slot_wdata, slot_rdata;
  logic                 fifo_we;
  logic [FREE_AW-1:0]   fifo_waddr, fifo_raddr;
  logic [ID_W-1:0]      fifo_wdata, fifo_rdata;

  scan_cmd_t scan_cmd;
  scan_st_t  scan_st;

  logic [LIM_W-1:0] lim;
  logic             pool_en;
  logic [LIM_W-1:0] id_ext;
  logic [ID_W-1:0]  wr_id;
  logic             wr_ok;
  logic             do_clear;

  ial_ram #(.WIDTH(WORD_BITS), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ial_ram #(.WIDTH(ID_W), .DEPTH(FREE_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  ial_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (scan_cmd),
    .st    (scan_st)
  );

  // effective limit, saturated to the table size
  assign lim     = (limit_r > LIM_W'(SLOT_COUNT)) ? LIM_W'(SLOT_COUNT) : limit_r;
  assign pool_en = LIM_W'(first_r) < lim;
  assign id_ext  = LIM_W'(id_r);

  // slot write check shared by add and set
  assign wr_id = (state_r == S_ADD_WR) ? g_r : id_r;
  assign wr_ok = (LIM_W'(wr_id) < fresh_r) && (LIM_W'(wr_id) < lim);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    data_nxt      = data_r;
    g_nxt         = g_r;
    first_nxt     = first_r;
    limit_nxt     = limit_r;
    fresh_nxt     = fresh_r;
    top_nxt       = top_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    res_ok_nxt    = res_ok_r;
    res_id_nxt    = res_id_r;
    res_data_nxt  = res_data_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    scan_cmd      = '0;
    slot_we       = 1'b0;
    slot_waddr    = SLOT_AW'(wr_id);
    slot_wdata    = data_r;
    slot_raddr    = SLOT_AW'(id_r);
    fifo_we       = 1'b0;
    fifo_waddr    = tail_r;
    fifo_wdata    = id_r;
    fifo_raddr    = head_r;
    do_clear      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.op;
          id_nxt       = in_data.id_in;
          data_nxt     = in_data.data_in;
          res_ok_nxt   = 1'b0;
          res_id_nxt   = '0;
          res_data_nxt = '0;
          state_nxt    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_nxt = S_RESP;
        if (pool_en) begin
          case (op_t'(op_r))
            OP_ADD: begin
              if (cnt_r != '0) begin
                // recycled ID: read the freed-ID RAM at the head
                head_nxt  = (head_r == FREE_AW'(FREE_DEPTH - 1)) ? '0
                                                                   : head_r + FREE_AW'(1);
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_FIFO_RD;
              end else if (fresh_r < lim) begin
                g_nxt     = ID_W'(fresh_r);
                fresh_nxt = fresh_r + LIM_W'(1);
                state_nxt = S_ADD_WR;
              end
            end
            OP_SET: begin
              if (wr_ok) begin
                slot_we         = 1'b1;
                scan_cmd.occ_we = 1'b1;
                scan_cmd.occ_idx = SLOT_AW'(id_r);
                scan_cmd.occ_val = (data_r != '0);
                if (id_r > top_r) begin
                  top_nxt = id_r;
                end
                res_ok_nxt = 1'b1;
              end
            end
            OP_GET: begin
              if (id_ext < lim) begin
                scan_cmd.load     = 1'b1;
                scan_cmd.load_idx = IDX_W'(id_r);
                state_nxt         = S_GET_DATA;
              end
            end
            OP_DEL: begin
              if (id_ext < lim) begin
                scan_cmd.occ_we  = 1'b1;
                scan_cmd.occ_idx = SLOT_AW'(id_r);
                scan_cmd.occ_val = 1'b0;
                if (id_r == top_r) begin
                  scan_cmd.load     = 1'b1;
                  scan_cmd.load_idx = IDX_W'(id_r);
                  state_nxt         = S_WALK;
                end else begin
                  state_nxt = S_RETURN;
                end
              end
            end
            OP_NEXT: begin
              if (id_ext < lim) begin
                scan_cmd.load     = 1'b1;
                scan_cmd.load_idx = IDX_W'(id_r) + IDX_W'(1);
                state_nxt         = S_SCAN_NEXT;
              end
            end
            OP_PREV: begin
              if (id_r != '0 && id_ext < lim) begin
                scan_cmd.load     = 1'b1;
                scan_cmd.load_idx = IDX_W'(id_r) - IDX_W'(1);
                state_nxt         = S_SCAN_PREV;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FIFO_RD: begin
        g_nxt     = fifo_rdata;
        state_nxt = S_ADD_WR;
      end

      S_ADD_WR: begin
        res_id_nxt = g_r;
        if (wr_ok) begin
          slot_we          = 1'b1;
          scan_cmd.occ_we  = 1'b1;
          scan_cmd.occ_idx = SLOT_AW'(g_r);
          scan_cmd.occ_val = (data_r != '0);
          if (g_r > top_r) begin
            top_nxt = g_r;
          end
          res_ok_nxt = 1'b1;
        end
        state_nxt = S_RESP;
      end

      S_GET_DATA: begin
        // empty slots read as zero whatever the RAM holds
        res_ok_nxt   = 1'b1;
        res_data_nxt = scan_st.hit ? slot_rdata : '0;
        state_nxt    = S_RESP;
      end

      S_WALK: begin
        // lower the top mark past empty slots
        if (scan_st.idx != '0 && !scan_st.hit) begin
          scan_cmd.step_dn = 1'b1;
        end else begin
          top_nxt = ID_W'(scan_st.idx);
          if (!scan_st.hit) begin
            do_clear   = 1'b1;
            res_ok_nxt = 1'b1;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_RETURN;
          end
        end
      end

      S_RETURN: begin
        state_nxt = S_RESP;
        if (id_r < first_r || LIM_W'(first_r) == fresh_r) begin
          res_ok_nxt = 1'b0;
        end else if (id_ext == fresh_r - LIM_W'(1)) begin
          fresh_nxt  = fresh_r - LIM_W'(1);
          res_ok_nxt = 1'b1;
        end else if (cnt_r >= CNT_W'(FREE_DEPTH)) begin
          res_ok_nxt = 1'b0;
        end else begin
          fifo_we    = 1'b1;
          tail_nxt   = (tail_r == FREE_AW'(FREE_DEPTH - 1)) ? '0 : tail_r + FREE_AW'(1);
          cnt_nxt    = cnt_r + CNT_W'(1);
          res_ok_nxt = 1'b1;
        end
      end

      S_SCAN_NEXT: begin
        if (scan_st.idx < IDX_W'(lim) && !scan_st.hit) begin
          scan_cmd.step_up = 1'b1;
        end else begin
          if (scan_st.idx < IDX_W'(lim)) begin
            res_ok_nxt = 1'b1;
            res_id_nxt = ID_W'(scan_st.idx);
          end
          state_nxt = S_RESP;
        end
      end

      S_SCAN_PREV: begin
        if (scan_st.idx != '0 && !scan_st.hit) begin
          scan_cmd.step_dn = 1'b1;
        end else begin
          if (scan_st.hit) begin
            res_ok_nxt = 1'b1;
            res_id_nxt = ID_W'(scan_st.idx);
          end
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.ok       = res_ok_r;
          out_nxt.id_out   = res_id_r;
          out_nxt.data_out = res_data_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes; either one empties the pool
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FIRST_ID: begin
          first_nxt = cfg_data[ID_W-1:0];
          do_clear  = 1'b1;
        end
        CFG_ID_LIMIT: begin
          limit_nxt = cfg_data[LIM_W-1:0];
          do_clear  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (do_clear) begin
      fresh_nxt        = LIM_W'(first_nxt);
      top_nxt          = '0;
      head_nxt         = '0;
      tail_nxt         = '0;
      cnt_nxt          = '0;
      scan_cmd.clr_all = 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      limit_r     <= LIM_W'(SLOT_COUNT);
      fresh_r     <= '0;
      top_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      limit_r     <= limit_nxt;
      fresh_r     <= fresh_nxt;
      top_r       <= top_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    data_r     <= data_nxt;
    g_r        <= g_nxt;
    res_ok_r   <= res_ok_nxt;
    res_id_r   <= res_id_nxt;
    res_data_r <= res_data_nxt;
    out_r      <= out_nxt;
  end

  `ASSERT_IMPL(a_fifo_empty_ptrs, cnt_r == '0, head_r == tail_r,
               "freed-ID queue empty but pointers differ")
  `ASSERT_ALWAYS(a_fresh_floor, fresh_r >= LIM_W'(first_r),
                 "fresh counter below first ID")
  `ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r == S_DISPATCH,
               "accepted word not dispatched")
  `ASSERT_IMPL(a_out_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP,
               "result raised outside the response state")

endmodule

>>> sv/ial_ram.sv
`timescale 1ns / 1ps
module ial_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ial_scan.sv
`timescale 1ns / 1ps
module ial_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  ial_pkg::scan_cmd_t cmd,
  output ial_pkg::scan_st_t  st
);
  import ial_pkg::*;

  // occupancy flag per slot: set only when the slot holds a nonzero word
  logic [SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.occ_we) begin
      occ_nxt[cmd.occ_idx] = cmd.occ_val;
    end
    if (cmd.clr_all) begin
      occ_nxt = '0;
    end
  end

  // walk index: load, or one step up or down per cycle
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = cmd.load_idx;
    end else if (cmd.step_up) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else if (cmd.step_dn) begin
      idx_nxt = idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign st.idx = idx_r;
  assign st.hit = (idx_r < IDX_W'(SLOT_COUNT)) && occ_r[idx_r[SLOT_AW-1:0]];

endmodule
